// ===== hw/rtl/camera_stream_header_deframer_assert.svh =====
// Assertion macros for the camera stream header deframer.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef CAMERA_STREAM_HEADER_DEFRAMER_ASSERT_SVH
`define CAMERA_STREAM_HEADER_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CSHD_ASSERT_IMPL(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CSHD_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CSHD_ASSERT_IMPL(lbl, clock, rstn, ante, cons, msg)
`define CSHD_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cshd_pkg.sv =====
package cshd_pkg;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_START_SYMBOL   = 2'd0,
		REG_CONNECT_OPCODE = 2'd1,
		REG_MAJOR_VER      = 2'd2,
		REG_MINOR_VER      = 2'd3
	} reg_idx_t;

	localparam logic [7:0] START_SYMBOL_RST   = 8'd0;
	localparam logic [7:0] CONNECT_OPCODE_RST = 8'd0;
	localparam logic [7:0] MAJOR_VER_RST      = 8'd1;
	localparam logic [7:0] MINOR_VER_RST      = 8'd1;

	// Bit of the flags byte that selects scanline mode
	localparam int SCANLINE_BIT = 7;

	// Result status codes
	typedef enum logic [2:0] {
		ST_IDLE          = 3'd0,
		ST_HEADER_BYTE   = 3'd1,
		ST_HEADER_OK     = 3'd2,
		ST_BAD_OPCODE    = 3'd3,
		ST_BAD_VERSION   = 3'd4,
		ST_TOO_MANY_CAMS = 3'd5,
		ST_HEIGHT_MISM   = 3'd6,
		ST_PIXEL         = 3'd7
	} status_t;

	// Parser phase
	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_OPCODE = 4'd1,
		PH_VMAJ   = 4'd2,
		PH_VMIN   = 4'd3,
		PH_COUNT  = 4'd4,
		PH_FLAGS  = 4'd5,
		PH_RES    = 4'd6,
		PH_FOPC   = 4'd7,
		PH_PIXEL  = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] start_symbol;
		logic [7:0] connect_opcode;
		logic [7:0] major_ver;
		logic [7:0] minor_ver;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  camera_index;
		logic [31:0] pixel_offset;
		logic [7:0]  pixel_value;
		logic        frame_end;
	} res_t;

endpackage

// ===== hw/rtl/cshd_byte_if.sv =====
interface cshd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/cshd_result_if.sv =====
interface cshd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  camera_index;
	logic [31:0] pixel_offset;
	logic [7:0]  pixel_value;
	logic        frame_end;

	modport source (
		output valid, output status, output camera_index, output pixel_offset,
		output pixel_value, output frame_end, input ready
	);
	modport sink (
		input valid, input status, input camera_index, input pixel_offset,
		input pixel_value, input frame_end, output ready
	);
endinterface

// ===== hw/rtl/cshd_apb_regs.sv =====
module cshd_apb_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cshd_pkg::cfg_t    cfg
);
	import cshd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_symbol   <= START_SYMBOL_RST;
			cfg_q.connect_opcode <= CONNECT_OPCODE_RST;
			cfg_q.major_ver      <= MAJOR_VER_RST;
			cfg_q.minor_ver      <= MINOR_VER_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_START_SYMBOL:   cfg_q.start_symbol   <= pwdata[7:0];
				REG_CONNECT_OPCODE: cfg_q.connect_opcode <= pwdata[7:0];
				REG_MAJOR_VER:      cfg_q.major_ver      <= pwdata[7:0];
				REG_MINOR_VER:      cfg_q.minor_ver      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_START_SYMBOL:   prdata[7:0] = cfg_q.start_symbol;
			REG_CONNECT_OPCODE: prdata[7:0] = cfg_q.connect_opcode;
			REG_MAJOR_VER:      prdata[7:0] = cfg_q.major_ver;
			REG_MINOR_VER:      prdata[7:0] = cfg_q.minor_ver;
			default: ;
		endcase
	end

	assign cfg = cfg_q;
endmodule

// ===== hw/rtl/cshd_parser.sv =====
module cshd_parser #(
	parameter int MAX_CAMERAS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_byte,
	input  cshd_pkg::cfg_t cfg,
	output cshd_pkg::res_t res
);
	import cshd_pkg::*;

	localparam int CW = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;

	// control state
	phase_t        phase_q, phase_d;
	logic [1:0]    hbyte_q, hbyte_d;
	logic [7:0]    camera_count_q, camera_count_d;
	logic          scanline_q, scanline_d;
	logic          header_valid_q, header_valid_d;
	logic          mismatch_q, mismatch_d;
	logic [CW-1:0] cursor_q, cursor_d;
	logic [CW-1:0] cam_q, cam_d;
	logic [15:0]   row_q, row_d;
	logic [15:0]   col_q, col_d;

	// payload state
	logic [15:0] widths_q [MAX_CAMERAS];
	logic [15:0] heights_q [MAX_CAMERAS];
	logic [7:0]  hi_q;
	logic [15:0] cur_w_q, cur_h_q;

	// next-state helpers
	logic             load;
	logic [CW-1:0]    load_idx;
	logic             wr_w, wr_h;
	logic [15:0]      res_word;
	logic [MAX_CAMERAS-1:0] mask;
	logic             first_found, next_found;
	logic [CW-1:0]    first_idx, next_idx;
	logic [CW:0]      next_from;
	logic             col_last, row_last_img, row_last_scn;
	logic [31:0]      prod;
	logic [CW:0]      cursor_inc;

	// cameras that hold pixels in the current mode
	always_comb begin
		for (int i = 0; i < MAX_CAMERAS; i++) begin
			mask[i] = (8'(i) < camera_count_q) && (widths_q[i] != 16'd0) &&
				(scanline_q || (heights_q[i] != 16'd0));
		end
	end

	// first listed camera, from zero and from the one after the current camera
	assign next_from = {1'b0, cam_q} + (CW+1)'(1);
	always_comb begin
		first_found = 1'b0;
		first_idx   = '0;
		next_found  = 1'b0;
		next_idx    = '0;
		for (int i = MAX_CAMERAS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				first_found = 1'b1;
				first_idx   = CW'(i);
			end
			if (mask[i] && ((CW+1)'(i) >= next_from)) begin
				next_found = 1'b1;
				next_idx   = CW'(i);
			end
		end
	end

	assign col_last     = ({1'b0, col_q} + 17'd1) >= {1'b0, cur_w_q};
	assign row_last_img = ({1'b0, row_q} + 17'd1) >= {1'b0, cur_h_q};
	assign row_last_scn = ({1'b0, row_q} + 17'd1) >= {1'b0, heights_q[0]};
	assign prod         = 32'(row_q) * 32'(cur_w_q);
	assign res_word     = {hi_q, data_byte};
	assign cursor_inc   = {1'b0, cursor_q} + (CW+1)'(1);

	// next state and result
	always_comb begin
		phase_d        = phase_q;
		hbyte_d        = hbyte_q;
		camera_count_d = camera_count_q;
		scanline_d     = scanline_q;
		header_valid_d = header_valid_q;
		mismatch_d     = mismatch_q;
		cursor_d       = cursor_q;
		cam_d          = cam_q;
		row_d          = row_q;
		col_d          = col_q;
		load           = 1'b0;
		load_idx       = first_idx;
		wr_w           = 1'b0;
		wr_h           = 1'b0;
		res            = '0;
		res.status     = ST_IDLE;

		unique case (phase_q)
			PH_HUNT: begin
				if (data_byte == cfg.start_symbol) begin
					if (header_valid_q) begin
						phase_d = PH_FOPC;
					end else begin
						phase_d    = PH_OPCODE;
						res.status = ST_HEADER_BYTE;
					end
				end
			end
			PH_OPCODE: begin
				if (data_byte == cfg.connect_opcode) begin
					res.status = ST_HEADER_BYTE;
					phase_d    = PH_VMAJ;
				end else begin
					res.status = ST_BAD_OPCODE;
					phase_d    = PH_HUNT;
				end
			end
			PH_VMAJ: begin
				if (data_byte == cfg.major_ver) begin
					res.status = ST_HEADER_BYTE;
					phase_d    = PH_VMIN;
				end else begin
					res.status = ST_BAD_VERSION;
					phase_d    = PH_HUNT;
				end
			end
			PH_VMIN: begin
				if (data_byte == cfg.minor_ver) begin
					res.status = ST_HEADER_BYTE;
					phase_d    = PH_COUNT;
				end else begin
					res.status = ST_BAD_VERSION;
					phase_d    = PH_HUNT;
				end
			end
			PH_COUNT: begin
				camera_count_d = data_byte;
				res.status     = ST_HEADER_BYTE;
				phase_d        = PH_FLAGS;
			end
			PH_FLAGS: begin
				scanline_d = data_byte[SCANLINE_BIT];
				if (camera_count_q > 8'(MAX_CAMERAS)) begin
					res.status = ST_TOO_MANY_CAMS;
					phase_d    = PH_HUNT;
				end else if (camera_count_q == 8'd0) begin
					res.status     = ST_HEADER_OK;
					header_valid_d = 1'b1;
					phase_d        = PH_HUNT;
				end else begin
					res.status = ST_HEADER_BYTE;
					hbyte_d    = 2'd0;
					cursor_d   = '0;
					mismatch_d = 1'b0;
					phase_d    = PH_RES;
				end
			end
			PH_RES: begin
				// width hi, width lo, height hi, height lo
				res.status = ST_HEADER_BYTE;
				hbyte_d    = hbyte_q + 2'd1;
				wr_w       = (hbyte_q == 2'd1);
				wr_h       = (hbyte_q == 2'd3);
				if (hbyte_q == 2'd3) begin
					cursor_d = cursor_inc[CW-1:0];
					if (scanline_q && (cursor_q != '0) && (res_word != heights_q[0])) begin
						mismatch_d = 1'b1;
					end
					if (8'(cursor_inc) >= camera_count_q) begin
						if (mismatch_d) begin
							res.status = ST_HEIGHT_MISM;
						end else begin
							res.status     = ST_HEADER_OK;
							header_valid_d = 1'b1;
						end
						phase_d = PH_HUNT;
					end
				end
			end
			PH_FOPC: begin
				// frame opcode byte is not checked; find the first pixel
				if (first_found && (scanline_q ? (heights_q[0] != 16'd0) : 1'b1)) begin
					cam_d   = first_idx;
					row_d   = '0;
					col_d   = '0;
					load    = 1'b1;
					phase_d = PH_PIXEL;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_PIXEL: begin
				res.status       = ST_PIXEL;
				res.camera_index = 2'(cam_q);
				res.pixel_offset = prod + 32'(col_q);
				res.pixel_value  = data_byte;
				if (!col_last) begin
					col_d = col_q + 16'd1;
				end else if (!scanline_q) begin
					// image mode: next row, then next camera
					if (!row_last_img) begin
						col_d = '0;
						row_d = row_q + 16'd1;
					end else if (next_found) begin
						cam_d    = next_idx;
						row_d    = '0;
						col_d    = '0;
						load     = 1'b1;
						load_idx = next_idx;
					end else begin
						res.frame_end = 1'b1;
						phase_d       = PH_HUNT;
					end
				end else begin
					// scanline mode: next camera, then next row
					if (next_found) begin
						cam_d    = next_idx;
						col_d    = '0;
						load     = 1'b1;
						load_idx = next_idx;
					end else if (!row_last_scn) begin
						cam_d = first_idx;
						row_d = row_q + 16'd1;
						col_d = '0;
						load  = 1'b1;
					end else begin
						res.frame_end = 1'b1;
						phase_d       = PH_HUNT;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			hbyte_q        <= '0;
			camera_count_q <= '0;
			scanline_q     <= 1'b0;
			header_valid_q <= 1'b0;
			mismatch_q     <= 1'b0;
			cursor_q       <= '0;
			cam_q          <= '0;
			row_q          <= '0;
			col_q          <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			hbyte_q        <= hbyte_d;
			camera_count_q <= camera_count_d;
			scanline_q     <= scanline_d;
			header_valid_q <= header_valid_d;
			mismatch_q     <= mismatch_d;
			cursor_q       <= cursor_d;
			cam_q          <= cam_d;
			row_q          <= row_d;
			col_q          <= col_d;
		end
	end

	// resolution table and current camera size
	always_ff @(posedge clk) begin
		if (step) begin
			if (phase_q == PH_RES) begin
				hi_q <= data_byte;
			end
			if (wr_w) begin
				widths_q[cursor_q] <= res_word;
			end
			if (wr_h) begin
				heights_q[cursor_q] <= res_word;
			end
			if (load) begin
				cur_w_q <= widths_q[load_idx];
				cur_h_q <= heights_q[load_idx];
			end
		end
	end
endmodule

// ===== hw/rtl/camera_stream_header_deframer.sv =====
// Camera stream header deframer.
// byte_in carries one received link byte per transaction; result_out carries one
// result per byte: status, camera index, pixel offset, pixel value, frame end.
// The block hunts for a start symbol, checks the connect header and stores the
// camera resolutions; later frames are routed pixel by pixel to camera/offset.
// The APB port sets the start symbol, connect opcode and expected versions;
// write it only while no byte is in flight.
// Throughput: one byte per cycle while result_out takes results. A byte enters
// an input register, the parser state machine and the row*width+column multiply
// act on it combinationally, and the result lands in the output register.
// When result_out stalls, the output register holds its result and the input
// register still takes one more byte; byte_in.ready then drops until the
// receiver takes the waiting result.
// Reset (arst_n low) empties both registers, restores the register defaults
// and returns the parser to hunting with no header accepted. The resolution
// table is not cleared; each header rewrites the entries it uses.
module camera_stream_header_deframer #(
	parameter int MAX_CAMERAS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	cshd_byte_if.sink     byte_in,
	cshd_result_if.source result_out
);
	import cshd_pkg::*;

	`include "camera_stream_header_deframer_assert.svh"

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       out_v_q;
	logic       v_s1;
	logic [7:0] data_s1;
	logic       adv;

	cshd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cshd_parser #(.MAX_CAMERAS(MAX_CAMERAS)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (data_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// stage 1 moves into the output register when that is free or draining
	assign adv           = v_s1 && (!out_v_q || result_out.ready);
	assign byte_in.ready = !v_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			v_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready) begin
			data_s1 <= byte_in.data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign result_out.valid        = out_v_q;
	assign result_out.status       = res_q.status;
	assign result_out.camera_index = res_q.camera_index;
	assign result_out.pixel_offset = res_q.pixel_offset;
	assign result_out.pixel_value  = res_q.pixel_value;
	assign result_out.frame_end    = res_q.frame_end;

	// checks
	`CSHD_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, byte_in.valid && byte_in.ready, v_s1, "accepted byte did not reach stage 1")
	`CSHD_ASSERT_NEXT(a_stall_keeps_s1, clk, arst_n, v_s1 && out_v_q && !result_out.ready, v_s1 && out_v_q, "byte lost while output stalled")
	`CSHD_ASSERT_IMPL(a_end_is_pixel, clk, arst_n, out_v_q && res_q.frame_end, res_q.status == ST_PIXEL, "frame end on a non-pixel result")
endmodule

// ===== dv/camera_stream_header_deframer_tb.sv =====
`timescale 1ns / 1ps

module camera_stream_header_deframer_tb;
	import cshd_pkg::*;

	localparam int MAX_CAMS = 4;
	localparam int PIPE_LAT = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cshd_byte_if   byte_ch ();
	cshd_result_if res_ch ();

	camera_stream_header_deframer #(
		.MAX_CAMERAS(MAX_CAMS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.byte_in   (byte_ch),
		.result_out(res_ch)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Deframer shadow state
	cfg_t        cfg;
	phase_t      ph;
	logic [2:0]  hdr_cnt;
	logic [7:0]  cam_cnt;
	logic        scan;
	logic [15:0] wid [MAX_CAMS];
	logic [15:0] hgt [MAX_CAMS];
	logic        hdr_ok;
	int          res_cur;
	int          cur_cam;
	int          cur_row;
	int          cur_col;

	res_t        routed_q [$];
	res_t        front;
	int          errors = 0;
	int          bytes_sent = 0;
	int          results_seen = 0;
	int          pixels_routed = 0;
	int          frames_closed = 0;
	int          hdr_rejects = 0;
	int          tx_max = 11;
	int          rx_max = 11;
	int          rx_hold = 0;

	// Accepted header as sent
	int          acc_n;
	logic        acc_scan;
	logic [15:0] acc_w [MAX_CAMS];
	logic [15:0] acc_h [MAX_CAMS];
	int          frame_len;

	// Step (cam,row,col) to the next position that holds a pixel
	function automatic bit next_pixel(inout int cam, inout int row, inout int col);
		int n;
		int i;
		bit any;
		n = int'(cam_cnt);
		any = 1'b0;
		if (n > MAX_CAMS)
			return 1'b0;
		if (!scan) begin
			while (cam < n) begin
				if (wid[cam] == 0 || hgt[cam] == 0) begin
					cam++;
					row = 0;
					col = 0;
				end else if (col >= wid[cam]) begin
					col = 0;
					row++;
				end else if (row >= hgt[cam]) begin
					cam++;
					row = 0;
					col = 0;
				end else begin
					return 1'b1;
				end
			end
			return 1'b0;
		end
		for (i = 0; i < n; i++)
			if (wid[i] != 0)
				any = 1'b1;
		if (n == 0 || !any)
			return 1'b0;
		// scanline: rows of all cameras side by side
		while (row < hgt[0]) begin
			if (cam >= n) begin
				row++;
				cam = 0;
				col = 0;
			end else if (col >= wid[cam]) begin
				cam++;
				col = 0;
			end else begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Expected result for one received byte; advances the shadow state
	function automatic res_t deframe_byte(input logic [7:0] b);
		res_t r;
		int   c;
		int   rw;
		int   k;
		int   i;
		bit   bad;
		r = '0;
		r.status = ST_IDLE;
		case (ph)
			PH_HUNT: begin
				if (b == cfg.start_symbol) begin
					if (hdr_ok) begin
						ph = PH_FOPC;
					end else begin
						ph = PH_OPCODE;
						r.status = ST_HEADER_BYTE;
					end
				end
			end
			PH_OPCODE: begin
				if (b == cfg.connect_opcode) begin
					r.status = ST_HEADER_BYTE;
					ph = PH_VMAJ;
				end else begin
					r.status = ST_BAD_OPCODE;
					ph = PH_HUNT;
				end
			end
			PH_VMAJ: begin
				if (b == cfg.major_ver) begin
					r.status = ST_HEADER_BYTE;
					ph = PH_VMIN;
				end else begin
					r.status = ST_BAD_VERSION;
					ph = PH_HUNT;
				end
			end
			PH_VMIN: begin
				if (b == cfg.minor_ver) begin
					r.status = ST_HEADER_BYTE;
					ph = PH_COUNT;
				end else begin
					r.status = ST_BAD_VERSION;
					ph = PH_HUNT;
				end
			end
			PH_COUNT: begin
				cam_cnt = b;
				r.status = ST_HEADER_BYTE;
				ph = PH_FLAGS;
			end
			PH_FLAGS: begin
				scan = b[SCANLINE_BIT];
				if (cam_cnt > MAX_CAMS) begin
					r.status = ST_TOO_MANY_CAMS;
					ph = PH_HUNT;
				end else if (cam_cnt == 0) begin
					r.status = ST_HEADER_OK;
					hdr_ok = 1'b1;
					ph = PH_HUNT;
				end else begin
					r.status = ST_HEADER_BYTE;
					hdr_cnt = '0;
					res_cur = 0;
					ph = PH_RES;
				end
			end
			PH_RES: begin
				c = res_cur;
				if (c >= MAX_CAMS) begin
					r.status = ST_TOO_MANY_CAMS;
					ph = PH_HUNT;
				end else begin
					// big-endian width then height
					case (hdr_cnt[1:0])
						2'd0: wid[c] = {b, 8'h00};
						2'd1: wid[c][7:0] = b;
						2'd2: hgt[c] = {b, 8'h00};
						default: hgt[c][7:0] = b;
					endcase
					r.status = ST_HEADER_BYTE;
					if (hdr_cnt[1:0] != 2'd3) begin
						hdr_cnt++;
					end else begin
						hdr_cnt = '0;
						res_cur = c + 1;
						if (res_cur >= cam_cnt) begin
							bad = 1'b0;
							if (scan)
								for (i = 1; i < cam_cnt && i < MAX_CAMS; i++)
									if (hgt[i] != hgt[0])
										bad = 1'b1;
							if (bad) begin
								r.status = ST_HEIGHT_MISM;
							end else begin
								r.status = ST_HEADER_OK;
								hdr_ok = 1'b1;
							end
							ph = PH_HUNT;
						end
					end
				end
			end
			PH_FOPC: begin
				// opcode byte of a frame is not checked
				c = 0;
				rw = 0;
				k = 0;
				if (next_pixel(c, rw, k)) begin
					cur_cam = c;
					cur_row = rw;
					cur_col = k;
					ph = PH_PIXEL;
				end else begin
					ph = PH_HUNT;
				end
			end
			PH_PIXEL: begin
				c = cur_cam;
				rw = cur_row;
				k = cur_col;
				r.status = ST_PIXEL;
				r.camera_index = c[1:0];
				r.pixel_offset = 32'(rw) * 32'(wid[c]) + 32'(k);
				r.pixel_value = b;
				k++;
				if (next_pixel(c, rw, k)) begin
					cur_cam = c;
					cur_row = rw;
					cur_col = k;
				end else begin
					r.frame_end = 1'b1;
					ph = PH_HUNT;
				end
			end
			default: ph = PH_HUNT;
		endcase
		if (r.status == ST_PIXEL)
			pixels_routed++;
		if (r.frame_end)
			frames_closed++;
		if (r.status inside {ST_BAD_OPCODE, ST_BAD_VERSION, ST_TOO_MANY_CAMS, ST_HEIGHT_MISM})
			hdr_rejects++;
		return r;
	endfunction

	task automatic report_err(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// Result checker and receiver stall draw
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (routed_q.size() == 0) begin
				report_err("result with no transaction outstanding", 32'(res_ch.status), 0);
			end else begin
				front = routed_q.pop_front();
				if (res_ch.status !== front.status)
					report_err("status", 32'(res_ch.status), 32'(front.status));
				if (res_ch.camera_index !== front.camera_index)
					report_err("camera_index", 32'(res_ch.camera_index),
						32'(front.camera_index));
				if (res_ch.pixel_offset !== front.pixel_offset)
					report_err("pixel_offset", res_ch.pixel_offset, front.pixel_offset);
				if (res_ch.pixel_value !== front.pixel_value)
					report_err("pixel_value", 32'(res_ch.pixel_value),
						32'(front.pixel_value));
				if (res_ch.frame_end !== front.frame_end)
					report_err("frame_end", 32'(res_ch.frame_end), 32'(front.frame_end));
			end
			rx_hold = $urandom_range(0, rx_max);
		end
	end

	// Receiver back-pressure
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				res_ch.ready = 1'b0;
				rx_hold--;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	// Send one link byte, with a random gap in front
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, tx_max);
		@(negedge clk);
		if (gap > 0) begin
			byte_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data_byte = b;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		routed_q.push_back(deframe_byte(b));
		bytes_sent++;
	endtask

	task automatic send_res(input logic [15:0] w, input logic [15:0] h);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
		send_byte(h[15:8]);
		send_byte(h[7:0]);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic wait_drained();
		@(negedge clk);
		byte_ch.valid = 1'b0;
		while (routed_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// APB write followed by a readback of the same register
	task automatic cfg_write(input reg_idx_t idx, input logic [7:0] val);
		logic [31:0] word;
		word = $urandom;
		word[7:0] = val;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_START_SYMBOL:   cfg.start_symbol = val;
			REG_CONNECT_OPCODE: cfg.connect_opcode = val;
			REG_MAJOR_VER:      cfg.major_ver = val;
			default:            cfg.minor_ver = val;
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[7:0] !== val)
			report_err("register readback", 32'(prdata[7:0]), 32'(val));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic cfg_all(input logic [7:0] st, input logic [7:0] op,
			input logic [7:0] vmaj, input logic [7:0] vmin);
		cfg_write(REG_START_SYMBOL, st);
		cfg_write(REG_CONNECT_OPCODE, op);
		cfg_write(REG_MAJOR_VER, vmaj);
		cfg_write(REG_MINOR_VER, vmin);
	endtask

	task automatic set_pace(input int mode);
		tx_max = (mode == 1 || mode == 3) ? 0 : 11;
		rx_max = (mode == 2 || mode == 3) ? 0 : 11;
	endtask

	// Random byte that does not start a frame
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == cfg.start_symbol);
		return b;
	endfunction

	// Header rejects under the reset register values
	task automatic test_header_errors();
		set_pace(0);
		send_byte(8'h5A);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h07);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(8'h05);
		send_byte(8'h80);
	endtask

	// Registers at their extremes; too many cameras and a height mismatch
	task automatic test_register_extremes();
		wait_drained();
		cfg_all(8'hFF, 8'hFF, 8'h00, 8'hFF);
		set_pace(3);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h7F);
		set_pace(0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h04);
		send_byte(8'h80);
		send_res(16'hFFFF, 16'hFFFF);
		send_res(16'h8000, 16'h0000);
		send_res(16'h0001, 16'hAAAA);
		send_res(16'h7FFE, 16'h5555);
	endtask

	// Well-formed header attempts that each fail at a random point
	task automatic test_random_rejects();
		int         n;
		int         kind;
		int         i;
		logic [15:0] h0;
		logic [7:0] b;
		wait_drained();
		cfg_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		for (n = 0; n < 40; n++) begin
			if (n % 10 == 0)
				set_pace($urandom_range(0, 3));
			repeat ($urandom_range(0, 2)) send_byte(noise_byte());
			kind = $urandom_range(0, 4);
			send_byte(cfg.start_symbol);
			if (kind == 0) begin
				do b = 8'($urandom); while (b == cfg.connect_opcode);
				send_byte(b);
				continue;
			end
			send_byte(cfg.connect_opcode);
			if (kind == 1) begin
				do b = 8'($urandom); while (b == cfg.major_ver);
				send_byte(b);
				continue;
			end
			send_byte(cfg.major_ver);
			if (kind == 2) begin
				do b = 8'($urandom); while (b == cfg.minor_ver);
				send_byte(b);
				continue;
			end
			send_byte(cfg.minor_ver);
			if (kind == 3) begin
				send_byte(8'($urandom_range(MAX_CAMS + 1, 255)));
				send_byte(8'($urandom));
				continue;
			end
			// scanline header with at least one height off
			b = 8'($urandom_range(2, MAX_CAMS));
			send_byte(b);
			send_byte({1'b1, 7'($urandom)});
			h0 = 16'($urandom);
			for (i = 0; i < b; i++)
				send_res(16'($urandom), (i == 0) ? h0 :
					(i == 1) ? (h0 ^ 16'($urandom_range(1, 65535))) : 16'($urandom));
		end
	endtask

	// Accept the one header that all later frames use
	task automatic test_accept_header();
		int         i;
		int         sum_w;
		logic [15:0] common_h;
		wait_drained();
		cfg_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		set_pace($urandom_range(0, 3));
		acc_n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, MAX_CAMS);
		acc_scan = 1'($urandom_range(0, 1));
		common_h = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
		frame_len = 0;
		sum_w = 0;
		for (i = 0; i < acc_n; i++) begin
			acc_w[i] = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
			acc_h[i] = acc_scan ? common_h :
				($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
			sum_w += acc_w[i];
			frame_len += acc_w[i] * acc_h[i];
		end
		if (acc_scan)
			frame_len = (sum_w == 0) ? 0 : sum_w * common_h;
		send_byte(cfg.start_symbol);
		send_byte(cfg.connect_opcode);
		send_byte(cfg.major_ver);
		send_byte(cfg.minor_ver);
		send_byte(8'(acc_n));
		send_byte({acc_scan, 7'($urandom)});
		for (i = 0; i < acc_n; i++)
			send_res(acc_w[i], acc_h[i]);
	endtask

	// Pixel frames with noise in between, over several register settings
	task automatic test_random_frames();
		int seg;
		int seg_start;
		int i;
		for (seg = 0; seg < 6; seg++) begin
			wait_drained();
			cfg_all((seg == 0) ? 8'h00 : (seg == 1) ? 8'hFF : 8'($urandom),
				8'($urandom),
				(seg == 1) ? 8'hFF : 8'($urandom),
				(seg == 0) ? 8'h00 : 8'($urandom));
			set_pace(seg % 4);
			seg_start = bytes_sent;
			while (bytes_sent - seg_start < 120) begin
				if ($urandom_range(0, 15) == 0)
					wait_drained();
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) send_byte(noise_byte());
				send_byte(cfg.start_symbol);
				send_byte(8'($urandom));
				for (i = 0; i < frame_len; i++)
					send_byte(($urandom_range(0, 15) == 0) ? cfg.start_symbol :
						8'($urandom));
			end
		end
	endtask

	// Watchdog
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		cfg.start_symbol = START_SYMBOL_RST;
		cfg.connect_opcode = CONNECT_OPCODE_RST;
		cfg.major_ver = MAJOR_VER_RST;
		cfg.minor_ver = MINOR_VER_RST;
		ph = PH_HUNT;
		hdr_cnt = '0;
		cam_cnt = '0;
		scan = 1'b0;
		hdr_ok = 1'b0;
		res_cur = 0;
		cur_cam = 0;
		cur_row = 0;
		cur_col = 0;
		for (int i = 0; i < MAX_CAMS; i++) begin
			wid[i] = '0;
			hgt[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_header_errors();
		test_register_extremes();
		test_random_rejects();
		test_accept_header();
		test_random_frames();

		wait_drained();
		$display("Sent %0d bytes, checked %0d results: %0d header rejects, %0d pixels",
			bytes_sent, results_seen, hdr_rejects, pixels_routed);
		$display("Accepted header: %0d cameras, %s mode, %0d pixels per frame, %0d frames",
			acc_n, acc_scan ? "scanline" : "image", frame_len, frames_closed);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cshd_pkg.sv
hw/rtl/cshd_byte_if.sv
hw/rtl/cshd_result_if.sv
hw/rtl/cshd_apb_regs.sv
hw/rtl/cshd_parser.sv
hw/rtl/camera_stream_header_deframer.sv
dv/camera_stream_header_deframer_tb.sv
